/* src/fbrt_pkg.sv */
// Shared types, constants and helper functions for the foreground box tracker.
`timescale 1ns / 1ps

package fbrt_pkg;

	// Frame size limits and derived widths
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// Register and field widths
	localparam int SIZE_W  = 12;
	localparam int PIX_W   = 8;
	localparam int OFF_W   = 13;
	localparam int SCALE_W = 12;
	localparam int PCT_W   = 7;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 3;

	// Risk arithmetic
	localparam int RISK_FULL = 25600;   // 100 percent in Q8
	localparam int PCT_FULL  = 100;
	localparam int Q_W       = 15;
	localparam int NUM_W     = SCALE_W + Q_W;
	localparam int DIFF_W    = 15;
	localparam int ALM_W     = SCALE_W + PCT_W;
	localparam int CNT_W     = $clog2(Q_W);

	// Register indexes
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_FG_LEVEL      = 3'd2;
	localparam logic [IDX_W-1:0] REG_DANGER_OFFSET = 3'd3;
	localparam logic [IDX_W-1:0] REG_DIST_SCALE    = 3'd4;
	localparam logic [IDX_W-1:0] REG_ALARM_PERCENT = 3'd5;

	// Register reset values
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_FG     = 255;
	localparam int RST_OFFSET = 100;
	localparam int RST_SCALE  = 124;
	localparam int RST_ALARM  = 70;

	// Control into the box tracker
	typedef struct packed {
		logic              accept;
		logic [PIX_W-1:0]  pixel;
		logic [PIX_W-1:0]  fg;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic              size_wr;
		logic [SIZE_W-1:0] new_w;
		logic [SIZE_W-1:0] new_h;
	} box_ctrl_t;

	// Status out of the box tracker: box as it stands after the current pixel
	typedef struct packed {
		logic              frame_end;
		logic [SIZE_W-1:0] left;
		logic [COL_W-1:0]  right;
		logic [SIZE_W-1:0] top;
		logic [ROW_W-1:0]  bottom;
	} box_stat_t;

	// Hold a frame width to 1..MAX_WIDTH
	function automatic logic [SIZE_W-1:0] clamp_width(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if ({1'b0, v} > (SIZE_W+1)'(MAX_WIDTH)) begin
			r = SIZE_W'(MAX_WIDTH);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Hold a frame height to 1..MAX_HEIGHT
	function automatic logic [SIZE_W-1:0] clamp_height(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if ({1'b0, v} > (SIZE_W+1)'(MAX_HEIGHT)) begin
			r = SIZE_W'(MAX_HEIGHT);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* src/fbrt_pix_if.sv */
// Pixel stream channel: valid, ready and one mask pixel.
`timescale 1ns / 1ps

interface fbrt_pix_if import fbrt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, pixel, input ready);
	modport sink (input valid, pixel, output ready);
endinterface

/* src/fbrt_res_if.sv */
// Result channel: valid, ready, bounding box, risk score and alarm.
`timescale 1ns / 1ps

interface fbrt_res_if import fbrt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] box_left;
	logic [COL_W-1:0]  box_right;
	logic [SIZE_W-1:0] box_top;
	logic [ROW_W-1:0]  box_bottom;
	logic [Q_W-1:0]    risk_q8;
	logic              alarm;

	modport source (output valid, box_left, box_right, box_top, box_bottom, risk_q8, alarm,
		input ready);
	modport sink (input valid, box_left, box_right, box_top, box_bottom, risk_q8, alarm,
		output ready);
endinterface

/* src/foreground_box_risk_tracker.sv */
// Top level: configuration registers, frame-end sequencer and result register.
// Frame end: after the last pixel of a frame the sequencer takes the distance,
//   clamp, numerator and divider-start steps, then waits on the one-bit-per-cycle restoring divider.
// Throughput: one pixel per cycle inside a frame; frame end blocks input until
//   the result is loaded into the output register, which waits while an unaccepted result holds it.
// Reset: arst_n clears all control state at once and restores register defaults.
`timescale 1ns / 1ps

module foreground_box_risk_tracker import fbrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	fbrt_pix_if.sink         pix,
	fbrt_res_if.source       res
);

	// Sequencer codes
	localparam logic [2:0] ST_SCAN  = 3'd0;
	localparam logic [2:0] ST_DIFF  = 3'd1;
	localparam logic [2:0] ST_CLAMP = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_START = 3'd4;
	localparam logic [2:0] ST_WAIT  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	// Configuration registers
	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic [PIX_W-1:0]   fg_q;
	logic [OFF_W-1:0]   offset_q;
	logic [SCALE_W-1:0] scale_q;
	logic [PCT_W-1:0]   alarm_pct_q;

	logic [2:0]         state_q;
	logic               res_valid_q;

	// Frame-end working registers
	logic [SIZE_W-1:0]  box_left_q;
	logic [COL_W-1:0]   box_right_q;
	logic [SIZE_W-1:0]  box_top_q;
	logic [ROW_W-1:0]   box_bottom_q;
	logic [DIFF_W-1:0]  diff_q;
	logic [SCALE_W-1:0] d_q;
	logic [SCALE_W-1:0] s_q;
	logic [NUM_W-1:0]   num_q;
	logic               alarm_q;

	// Output register
	logic [SIZE_W-1:0]  out_left_q;
	logic [COL_W-1:0]   out_right_q;
	logic [SIZE_W-1:0]  out_top_q;
	logic [ROW_W-1:0]   out_bottom_q;
	logic [Q_W-1:0]     out_risk_q;
	logic               out_alarm_q;

	logic [SIZE_W-1:0]  eff_w;
	logic [SIZE_W-1:0]  eff_h;
	logic               accept;
	logic               load_out;
	box_ctrl_t          box_ctrl;
	box_stat_t          box_stat;

	logic [DIFF_W-1:0]  centre_c;
	logic [DIFF_W-1:0]  diff_c;
	logic [DIFF_W-1:0]  abs_c;
	logic [SCALE_W-1:0] s_c;
	logic [ALM_W-1:0]   alarm_lhs;
	logic [ALM_W-1:0]   alarm_rhs;
	logic               div_done;
	logic [Q_W-1:0]     div_quo;

	assign eff_w     = clamp_width(width_q);
	assign eff_h     = clamp_height(height_q);
	assign pix.ready = state_q == ST_SCAN;
	assign accept    = pix.valid && pix.ready;
	assign load_out  = state_q == ST_DONE && (!res_valid_q || res.ready);

	// Feed the box tracker; a size write carries its clamped new value
	always_comb begin
		box_ctrl.accept  = accept;
		box_ctrl.pixel   = pix.pixel;
		box_ctrl.fg      = fg_q;
		box_ctrl.width   = eff_w;
		box_ctrl.height  = eff_h;
		box_ctrl.size_wr = cfg_write &&
			(cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
		box_ctrl.new_w   = cfg_index == REG_FRAME_WIDTH ?
			clamp_width(cfg_data[SIZE_W-1:0]) : eff_w;
		box_ctrl.new_h   = cfg_index == REG_FRAME_HEIGHT ?
			clamp_height(cfg_data[SIZE_W-1:0]) : eff_h;
	end

	fbrt_box u_box (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (box_ctrl),
		.stat   (box_stat)
	);

	// Distance from the danger column, magnitude clamped to the scale
	always_comb begin
		centre_c = DIFF_W'({1'b0, eff_w[SIZE_W-1:1]}) +
			{{(DIFF_W-OFF_W){offset_q[OFF_W-1]}}, offset_q};
		diff_c   = DIFF_W'(box_right_q) - centre_c;
		abs_c    = diff_q[DIFF_W-1] ? (~diff_q + DIFF_W'(1)) : diff_q;
		s_c      = (scale_q == '0) ? SCALE_W'(1) : scale_q;
		alarm_lhs = ALM_W'(PCT_FULL) * ALM_W'(s_q - d_q);
		alarm_rhs = ALM_W'(alarm_pct_q) * ALM_W'(s_q);
	end

	// Ceiling division: (d * 25600 + s - 1) / s
	fbrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.num    (num_q),
		.den    (s_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= SIZE_W'(RST_WIDTH);
			height_q    <= SIZE_W'(RST_HEIGHT);
			fg_q        <= PIX_W'(RST_FG);
			offset_q    <= OFF_W'(RST_OFFSET);
			scale_q     <= SCALE_W'(RST_SCALE);
			alarm_pct_q <= PCT_W'(RST_ALARM);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   width_q     <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT:  height_q    <= cfg_data[SIZE_W-1:0];
				REG_FG_LEVEL:      fg_q        <= cfg_data[PIX_W-1:0];
				REG_DANGER_OFFSET: offset_q    <= cfg_data[OFF_W-1:0];
				REG_DIST_SCALE:    scale_q     <= cfg_data[SCALE_W-1:0];
				REG_ALARM_PERCENT: alarm_pct_q <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SCAN:  if (box_stat.frame_end) state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_PREP;
				ST_PREP:  state_q <= ST_START;
				ST_START: state_q <= ST_WAIT;
				ST_WAIT:  if (div_done) state_q <= ST_DONE;
				ST_DONE:  if (load_out) state_q <= ST_SCAN;
				default:  state_q <= ST_SCAN;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (box_stat.frame_end) begin
			// hold the finished box while the tracker reloads
			box_left_q   <= box_stat.left;
			box_right_q  <= box_stat.right;
			box_top_q    <= box_stat.top;
			box_bottom_q <= box_stat.bottom;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= diff_c;
		end
		if (state_q == ST_CLAMP) begin
			s_q <= s_c;
			d_q <= (abs_c > DIFF_W'(s_c)) ? s_c : abs_c[SCALE_W-1:0];
		end
		if (state_q == ST_PREP) begin
			num_q <= NUM_W'(d_q) * NUM_W'(RISK_FULL) + NUM_W'(s_q) - NUM_W'(1);
		end
		if (state_q == ST_START) begin
			alarm_q <= alarm_lhs > alarm_rhs;
		end
		if (load_out) begin
			out_left_q   <= box_left_q;
			out_right_q  <= box_right_q;
			out_top_q    <= box_top_q;
			out_bottom_q <= box_bottom_q;
			out_risk_q   <= Q_W'(RISK_FULL) - div_quo;
			out_alarm_q  <= alarm_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.box_left   = out_left_q;
	assign res.box_right  = out_right_q;
	assign res.box_top    = out_top_q;
	assign res.box_bottom = out_bottom_q;
	assign res.risk_q8    = out_risk_q;
	assign res.alarm      = out_alarm_q;

	// Divider finishes only while the sequencer waits for it
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_WAIT)
		else $error("divider done outside wait state");

	// A new result appears only out of the hand-off state
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside hand-off");

	// Clamped distance never exceeds the scale
	a_clamp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PREP |-> d_q <= s_q)
		else $error("distance above scale");

	// Risk score stays within 100 percent
	a_risk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> out_risk_q <= Q_W'(RISK_FULL))
		else $error("risk score out of range");

	// Frame end, seen only while pixels are taken, moves the sequencer to the distance step
	a_frame_end_scan: assert property (@(posedge clk) disable iff (!arst_n)
		box_stat.frame_end |=> state_q == ST_DIFF)
		else $error("frame end not followed by distance step");

endmodule

/* src/fbrt_box.sv */
// Raster counters and bounding box of foreground pixels.
`timescale 1ns / 1ps

module fbrt_box import fbrt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  box_ctrl_t ctrl,
	output box_stat_t stat
);

	logic [COL_W-1:0]  column_q;
	logic [ROW_W-1:0]  row_q;
	logic [SIZE_W-1:0] left_q;
	logic [COL_W-1:0]  right_q;
	logic [SIZE_W-1:0] top_q;
	logic [ROW_W-1:0]  bottom_q;

	logic              hit;
	logic              last_col;
	logic              last_row;
	logic [SIZE_W-1:0] left_n;
	logic [COL_W-1:0]  right_n;
	logic [SIZE_W-1:0] top_n;
	logic [ROW_W-1:0]  bottom_n;

	always_comb begin
		hit      = ctrl.pixel == ctrl.fg;
		last_col = !(((SIZE_W+1)'(column_q) + (SIZE_W+1)'(1)) < (SIZE_W+1)'(ctrl.width));
		last_row = !(((SIZE_W+1)'(row_q) + (SIZE_W+1)'(1)) < (SIZE_W+1)'(ctrl.height));
		left_n   = left_q;
		right_n  = right_q;
		top_n    = top_q;
		bottom_n = bottom_q;
		if (hit) begin
			if (SIZE_W'(column_q) < left_q) left_n = SIZE_W'(column_q);
			if (column_q > right_q) right_n = column_q;
			if (SIZE_W'(row_q) < top_q) top_n = SIZE_W'(row_q);
			if (row_q > bottom_q) bottom_n = row_q;
		end
		stat.frame_end = ctrl.accept && last_col && last_row;
		stat.left      = left_n;
		stat.right     = right_n;
		stat.top       = top_n;
		stat.bottom    = bottom_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			left_q   <= SIZE_W'(RST_WIDTH);
			right_q  <= '0;
			top_q    <= SIZE_W'(RST_HEIGHT);
			bottom_q <= '0;
		end else if (ctrl.accept) begin
			if (last_col) begin
				column_q <= '0;
				if (last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				column_q <= column_q + COL_W'(1);
			end
			if (stat.frame_end) begin
				// reload the empty box for the next frame
				left_q   <= ctrl.width;
				right_q  <= '0;
				top_q    <= ctrl.height;
				bottom_q <= '0;
			end else begin
				left_q   <= left_n;
				right_q  <= right_n;
				top_q    <= top_n;
				bottom_q <= bottom_n;
			end
		end else if (ctrl.size_wr && column_q == '0 && row_q == '0) begin
			// size change before the first pixel picks up new sentinels
			left_q   <= ctrl.new_w;
			right_q  <= '0;
			top_q    <= ctrl.new_h;
			bottom_q <= '0;
		end
	end

endmodule

/* src/fbrt_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fbrt_div import fbrt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [SCALE_W-1:0] den,
	output logic               done,
	output logic [Q_W-1:0]     quo
);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SCALE_W-1:0] rem_q;
	logic [Q_W-1:0]     quo_q;
	logic [SCALE_W-1:0] den_q;

	logic [SCALE_W:0]   trial;
	logic [SCALE_W:0]   diff;
	logic               ge;

	always_comb begin
		trial = {rem_q, quo_q[Q_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = !diff[SCALE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator is below den * 2^Q_W, so its top bits start below den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:Q_W];
			quo_q <= num[Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* bench/foreground_box_risk_tracker_tb.sv */
// Self-checking testbench for the foreground box tracker: bounding box, risk score and alarm.
`timescale 1ns / 1ps

module foreground_box_risk_tracker_tb;
	import fbrt_pkg::*;

	// Run shape
	localparam int HOLD_OFF_CYCLES = 400;   // long result back-pressure stretch
	localparam int STALL_LIMIT     = 3000;  // cycles with no transfer before giving up
	localparam int SETTLE_CYCLES   = 30;    // lets the frame-end pass drain, with margin
	localparam int WIDE_PIXELS     = 300;   // partial line under the held widest width
	localparam int TALL_PIXELS     = 200;   // partial frame under the held tallest height
	localparam int RANDOM_PIXELS   = 1300;

	// Indexes past the last register: writes there must change nothing
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Result-side ready patterns
	typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM} ready_pattern_t;

	// One frame result as the block should report it
	typedef struct {
		logic [SIZE_W-1:0] left;
		logic [COL_W-1:0]  right;
		logic [SIZE_W-1:0] top;
		logic [ROW_W-1:0]  bottom;
		logic [Q_W-1:0]    risk;
		logic              alarm;
	} frame_box_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_write;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	fbrt_pix_if pix_ch ();
	fbrt_res_if box_ch ();

	foreground_box_risk_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_ch),
		.res       (box_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Box predictor: own copy of the registers and the frame state
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0]        frame_width;
	logic [SIZE_W-1:0]        frame_height;
	logic [PIX_W-1:0]         fg_level;
	logic signed [OFF_W-1:0]  danger_offset;
	logic [SCALE_W-1:0]       distance_scale;
	logic [PCT_W-1:0]         alarm_percent;

	logic [COL_W-1:0]  column;
	logic [ROW_W-1:0]  row;
	logic [SIZE_W-1:0] left_edge;
	logic [COL_W-1:0]  right_edge;
	logic [SIZE_W-1:0] top_edge;
	logic [ROW_W-1:0]  bottom_edge;

	frame_box_t expected_boxes[$];

	// Size registers are held to 1..limit before use
	function automatic logic [SIZE_W-1:0] held_size(input logic [SIZE_W-1:0] v, input int limit);
		if (v == '0)
			return SIZE_W'(1);
		if (int'(v) > limit)
			return SIZE_W'(limit);
		return v;
	endfunction

	// Load the empty-box sentinels from the sizes now in effect
	function automatic void restart_box();
		left_edge   = held_size(frame_width, MAX_WIDTH);
		right_edge  = '0;
		top_edge    = held_size(frame_height, MAX_HEIGHT);
		bottom_edge = '0;
	endfunction

	function automatic void apply_register(input logic [IDX_W-1:0] idx,
		input logic [CFG_W-1:0] data);
		case (idx)
			REG_FRAME_WIDTH:   frame_width    = data[SIZE_W-1:0];
			REG_FRAME_HEIGHT:  frame_height   = data[SIZE_W-1:0];
			REG_FG_LEVEL:      fg_level       = data[PIX_W-1:0];
			REG_DANGER_OFFSET: danger_offset  = data[OFF_W-1:0];
			REG_DIST_SCALE:    distance_scale = data[SCALE_W-1:0];
			REG_ALARM_PERCENT: alarm_percent  = data[PCT_W-1:0];
			default: return;
		endcase
		// A size write before the first pixel of a frame refreshes the sentinels
		if ((idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) && column == '0 && row == '0)
			restart_box();
	endfunction

	// Fold one accepted pixel into the box; at frame end queue the expected result
	function automatic void fold_pixel(input logic [PIX_W-1:0] p);
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		longint            centre;
		longint            diff;
		longint            d;
		longint            s;
		frame_box_t        box;
		w = held_size(frame_width, MAX_WIDTH);
		h = held_size(frame_height, MAX_HEIGHT);
		if (p == fg_level) begin
			if (column < left_edge)   left_edge   = SIZE_W'(column);
			if (column > right_edge)  right_edge  = column;
			if (row < top_edge)       top_edge    = SIZE_W'(row);
			if (row > bottom_edge)    bottom_edge = row;
		end
		// A line ends once the column reaches the last one, even after a size shrink
		if (column + 12'd1 < w) begin
			column = column + 1'b1;
			return;
		end
		column = '0;
		if (row + 12'd1 < h) begin
			row = row + 1'b1;
			return;
		end
		row = '0;

		// Distance of the right edge from the danger column, clipped at the scale;
		// an empty frame measures from column zero
		centre = longint'(w / 2) + longint'(danger_offset);
		diff   = longint'(right_edge) - centre;
		d      = (diff < 0) ? -diff : diff;
		s      = (distance_scale == '0) ? 1 : longint'(distance_scale);
		if (d > s)
			d = s;

		box.left   = left_edge;
		box.right  = right_edge;
		box.top    = top_edge;
		box.bottom = bottom_edge;
		// Risk rounds down, so the subtracted part rounds up
		box.risk   = Q_W'(RISK_FULL - (d * RISK_FULL + s - 1) / s);
		// Exact comparison; a threshold above 100 can never trip
		box.alarm  = (PCT_FULL * (s - d)) > (longint'(alarm_percent) * s);
		expected_boxes.push_back(box);
		restart_box();
	endfunction

	// ------------------------------------------------------------------
	// Error reporting
	// ------------------------------------------------------------------
	int unsigned failures;

	task automatic report_error(input string msg);
		failures++;
		if (failures <= 40)
			$display("[%0t] ERROR: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [Q_W:0] got, input logic [Q_W:0] want);
		if (got !== want)
			report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Pixel driver: bursts of random length with random gaps
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] pixel_queue[$];
	int unsigned      pixels_queued;
	int unsigned      pixels_accepted;
	logic             pix_taken;
	int unsigned      burst_left = 1;
	int unsigned      gap_left;

	function automatic void queue_pixel(input logic [PIX_W-1:0] p);
		pixel_queue.push_back(p);
		pixels_queued++;
	endfunction

	// Queue count pixels; each is forced to foreground with fg_share percent chance
	function automatic void queue_frames(input int unsigned count, input int unsigned fg_share);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < fg_share)
				queue_pixel(fg_level);
			else
				queue_pixel(PIX_W'($urandom_range(0, 255)));
		end
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else if (!pix_ch.valid || pix_taken) begin
			// Previous pixel gone (or none offered): idle out the gap or offer the next
			if (gap_left != 0 || pixel_queue.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				pix_ch.valid <= 1'b0;
			end else begin
				pix_ch.valid <= 1'b1;
				pix_ch.pixel <= pixel_queue.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else if ($urandom_range(0, 3) == 0) begin
					// long stretch with no idling
					burst_left = $urandom_range(64, 256);
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = $urandom_range(1, 6);
				end
			end
		end
	end

	// Sample pixel transfers on the rising edge and advance the predictor
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			fold_pixel(pix_ch.pixel);
			pixels_accepted++;
			pix_taken <= 1'b1;
		end else begin
			pix_taken <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: its own stall pattern plus long hold-offs
	// ------------------------------------------------------------------
	int unsigned    boxes_seen;
	int unsigned    alarms_seen;
	int unsigned    holds_done;
	int unsigned    hold_left;
	int unsigned    mode_left;
	ready_pattern_t stall_mode = READY_ALWAYS;

	always @(negedge clk) begin
		if (!arst_n) begin
			box_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			box_ch.ready <= 1'b0;
		end else if (holds_done < 2 && boxes_seen >= 30 + 50 * holds_done
			&& pixel_queue.size() > 40) begin
			// Hold off while pixels keep coming, so the block backs up into its input
			hold_left = HOLD_OFF_CYCLES;
			holds_done++;
			box_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = ready_pattern_t'($urandom_range(0, 2));
				mode_left  = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				READY_ALWAYS: box_ch.ready <= 1'b1;
				READY_MOSTLY: box_ch.ready <= ($urandom_range(0, 3) != 0);
				default:      box_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Compare each result transfer with the oldest predicted frame
	always @(posedge clk) begin
		frame_box_t want;
		if (arst_n && box_ch.valid && box_ch.ready) begin
			boxes_seen++;
			if (box_ch.alarm)
				alarms_seen++;
			if (expected_boxes.size() == 0) begin
				report_error($sformatf("result with no frame pending: box %0d..%0d x %0d..%0d risk %0d",
					box_ch.box_left, box_ch.box_right, box_ch.box_top, box_ch.box_bottom,
					box_ch.risk_q8));
			end else begin
				want = expected_boxes.pop_front();
				check_field("box_left",   box_ch.box_left,   want.left);
				check_field("box_right",  box_ch.box_right,  want.right);
				check_field("box_top",    box_ch.box_top,    want.top);
				check_field("box_bottom", box_ch.box_bottom, want.bottom);
				check_field("risk_q8",    box_ch.risk_q8,    want.risk);
				check_field("alarm",      box_ch.alarm,      want.alarm);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	int unsigned quiet_cycles;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_ch.valid && pix_ch.ready) || (box_ch.valid && box_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("No transfer for %0d cycles, %0d frame results outstanding",
					quiet_cycles, expected_boxes.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Configuration and sequencing
	// ------------------------------------------------------------------
	int unsigned register_writes;
	int unsigned settings;

	// Drive one register write; the predictor takes it at the same time,
	// which is safe because writes only happen while no pixel is in flight
	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		apply_register(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
		register_writes++;
	endtask

	// Wait until every pixel is taken and every frame result has come back,
	// then let the frame-end pass drain completely
	task automatic settle();
		while (pixels_accepted != pixels_queued || expected_boxes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return SIZE_W'($urandom_range(9, 16));
			default: return SIZE_W'($urandom_range(1, 8));
		endcase
	endfunction

	initial begin
		int unsigned      random_pixels;
		int unsigned      area;
		int unsigned      count;
		int unsigned      share;
		logic [CFG_W-1:0] value;

		// Every input known from time zero
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = REG_FRAME_WIDTH;
		cfg_data     = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		box_ch.ready = 1'b0;

		// Predictor starts from the register defaults
		frame_width    = SIZE_W'(RST_WIDTH);
		frame_height   = SIZE_W'(RST_HEIGHT);
		fg_level       = PIX_W'(RST_FG);
		danger_offset  = OFF_W'(RST_OFFSET);
		distance_scale = SCALE_W'(RST_SCALE);
		alarm_percent  = PCT_W'(RST_ALARM);
		column         = '0;
		row            = '0;
		restart_box();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Small 4x3 frame, offset at its most negative so the risk clips to zero,
		// zero scale read as one, threshold above 100 so the alarm stays off
		settings++;
		write_register(REG_FRAME_WIDTH, 13'd4);
		write_register(REG_FRAME_HEIGHT, 13'd3);
		write_register(REG_FG_LEVEL, 13'd255);
		write_register(REG_DANGER_OFFSET, 13'h1000);
		write_register(REG_DIST_SCALE, 13'd0);
		write_register(REG_ALARM_PERCENT, 13'd127);
		queue_pixel(8'd255); queue_pixel(8'd0);   queue_pixel(8'd0);   queue_pixel(8'd255);
		queue_pixel(8'd0);   queue_pixel(8'd128); queue_pixel(8'd255); queue_pixel(8'd0);
		queue_pixel(8'd255); queue_pixel(8'd0);   queue_pixel(8'd0);   queue_pixel(8'd1);
		// Empty frame: sentinels come back as width and height
		for (int i = 0; i < 12; i++)
			queue_pixel((i % 2) ? 8'd254 : 8'd0);

		// Zero sizes held to one pixel per frame; largest offset and scale,
		// foreground level zero, threshold exactly 100
		settle();
		settings++;
		write_register(REG_FRAME_WIDTH, 13'd0);
		write_register(REG_FRAME_HEIGHT, 13'd0);
		write_register(REG_FG_LEVEL, 13'd0);
		write_register(REG_DANGER_OFFSET, 13'h0FFF);
		write_register(REG_DIST_SCALE, 13'd4095);
		write_register(REG_ALARM_PERCENT, 13'd100);
		queue_pixel(8'd0);
		queue_pixel(8'd255);
		queue_pixel(8'd0);

		// Danger column on the box: full risk, which does not exceed 100
		settle();
		settings++;
		write_register(REG_DANGER_OFFSET, 13'd0);
		queue_pixel(8'd0);
		queue_pixel(8'd7);

		// Oversized width held to the widest line; a long partial line with foreground
		// only where a random pixel happens to match the level
		settle();
		settings++;
		write_register(REG_FRAME_WIDTH, 13'h0FFF);
		write_register(REG_FRAME_HEIGHT, 13'd1);
		write_register(REG_FG_LEVEL, 13'h0AA);
		write_register(REG_DANGER_OFFSET, 13'd900);
		write_register(REG_ALARM_PERCENT, 13'd90);
		queue_frames(WIDE_PIXELS, 0);

		// Width cut to one mid-line: the next pixel ends the line and the frame
		settle();
		settings++;
		write_register(REG_FRAME_WIDTH, 13'd1);
		queue_pixel(8'd0);

		// Tall frame one pixel wide, height held down from an oversized value
		settle();
		settings++;
		write_register(REG_FRAME_HEIGHT, 13'h0FFF);
		queue_frames(TALL_PIXELS - 1, 2);
		queue_pixel(fg_level);

		// Height cut mid-frame: the next line end closes the frame
		settle();
		settings++;
		write_register(REG_FRAME_HEIGHT, 13'd4);
		queue_pixel(fg_level);

		// Random settings with mostly small frames. A phase may stop part way
		// through a frame, so the next size write lands mid-frame.
		while (random_pixels < RANDOM_PIXELS) begin
			settle();
			settings++;
			if ($urandom_range(0, 9) < 6)
				write_register(REG_FRAME_WIDTH, {1'($urandom), pick_size()});
			if ($urandom_range(0, 9) < 6)
				write_register(REG_FRAME_HEIGHT, {1'($urandom), pick_size()});
			if ($urandom_range(0, 9) < 4)
				write_register(REG_FG_LEVEL, CFG_W'($urandom));
			if ($urandom_range(0, 9) < 5) begin
				// mostly near the frame centre, where the risk is graded
				value = ($urandom_range(0, 9) < 7) ? CFG_W'($urandom_range(0, 24) - 12)
					: CFG_W'($urandom);
				write_register(REG_DANGER_OFFSET, value);
			end
			if ($urandom_range(0, 9) < 5) begin
				case ($urandom_range(0, 9))
					0:       value = '0;
					1:       value = CFG_W'($urandom);
					default: value = CFG_W'($urandom_range(1, 16));
				endcase
				write_register(REG_DIST_SCALE, value);
			end
			if ($urandom_range(0, 9) < 5)
				write_register(REG_ALARM_PERCENT, CFG_W'($urandom));
			if ($urandom_range(0, 19) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));

			area  = int'(held_size(frame_width, MAX_WIDTH)) * int'(held_size(frame_height, MAX_HEIGHT));
			count = $urandom_range(1, 8) * area;
			if ($urandom_range(0, 3) == 0)
				count += $urandom_range(1, area);
			case ($urandom_range(0, 4))
				0:       share = 0;
				1:       share = 5;
				2:       share = 25;
				3:       share = 60;
				default: share = 100;
			endcase
			queue_frames(count, share);
			random_pixels += count;
		end

		settle();
		$display("Covered %0d pixel transfers and %0d frame results, %0d of them with the alarm set.",
			pixels_accepted, boxes_seen, alarms_seen);
		$display("Used %0d register settings over %0d writes, with %0d long result hold-offs.",
			settings, register_writes, holds_done);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
